// ===== hw/rtl/hmt_pkg.sv =====
// Package for the horizon mask test block: shared types, register indexes,
// opcodes and reset values. No dependencies.
package hmt_pkg;

    localparam int AZ_W      = 16;
    localparam int ALT_W     = 15;
    localparam int CNT_CFG_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam logic [AZ_W-1:0] AZ_FULL = 16'd36000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [ALT_W-1:0] MIN_ALT_RST = -15'sd9000;
    localparam logic signed [ALT_W-1:0] MAX_ALT_RST = 15'sd9000;

    typedef struct packed {
        logic [AZ_W-1:0]          az;
        logic signed [ALT_W-1:0]  alt;
    } point_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic first;
    } seg_ctl_t;

    typedef struct packed {
        logic busy;
        logic acc;
    } seg_sts_t;

    // Azimuth modulo 36000 for any 16-bit value (one conditional subtract).
    function automatic logic [AZ_W-1:0] az_reduce(input logic [AZ_W-1:0] az);
        logic [AZ_W-1:0] r;
        r = (az >= AZ_FULL) ? az - AZ_FULL : az;
        return r;
    endfunction

endpackage

// ===== hw/rtl/horizon_mask_test.sv =====
// Horizon mask top: config, handshake, sequencer. Uses hmt_pkg, hmt_point_mem, hmt_seg_unit.
// Point write: one transaction per cycle while no query is in progress, no result. Query over N
// outline points: N+1 reads incl. point 0 re-read, drain of the segment unit, then the
// registered result; out-of-limit or empty outline: no reads, straight to the result.
// A waiting result stalls the query; the next item is taken only once back in idle.
// Async active-low reset restores limit/count defaults; point memory is not cleared.
module horizon_mask_test #(
    parameter int MAX_POINTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               opcode,
    input  logic [5:0]                         point_index,
    input  logic [hmt_pkg::AZ_W-1:0]           azimuth,
    input  logic signed [hmt_pkg::ALT_W-1:0]   altitude,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               under_horizon,
    input  logic                               cfg_we,
    input  logic [hmt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hmt_pkg::CFG_W-1:0]          cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic signed [hmt_pkg::ALT_W-1:0] min_alt_reg;
    logic signed [hmt_pkg::ALT_W-1:0] max_alt_reg;
    logic [hmt_pkg::CNT_CFG_W-1:0]    count_reg;

    logic signed [hmt_pkg::ALT_W-1:0] alt_reg, alt_next;
    logic [hmt_pkg::AZ_W-1:0]         azm_reg, azm_next;
    logic                             oor_reg, oor_next;
    logic [CNT_W-1:0]                 n_reg, n_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic                             rd_first_reg, rd_first_next;
    logic                             res_valid_reg, res_valid_next;
    logic                             res_bit_reg, res_bit_next;

    logic                             accept;
    logic                             oor_cur;
    logic [CNT_W-1:0]                 n_cur;
    logic                             seg_clear;
    logic                             mem_we;
    logic [AW-1:0]                    raddr;
    hmt_pkg::point_t                  wdata;
    hmt_pkg::point_t                  rdata;
    hmt_pkg::seg_ctl_t                seg_ctl;
    hmt_pkg::seg_sts_t                seg_sts;

    assign item_ready    = (state_reg == ST_IDLE);
    assign accept        = item_valid && item_ready;
    assign result_valid  = res_valid_reg;
    assign under_horizon = res_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_alt_reg <= hmt_pkg::MIN_ALT_RST;
            max_alt_reg <= hmt_pkg::MAX_ALT_RST;
            count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hmt_pkg::CFG_MIN_ALT: min_alt_reg <= $signed(cfg_data);
                hmt_pkg::CFG_MAX_ALT: max_alt_reg <= $signed(cfg_data);
                hmt_pkg::CFG_POINTS:  count_reg   <= cfg_data[hmt_pkg::CNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign wdata.az  = hmt_pkg::az_reduce(azimuth);
    assign wdata.alt = altitude;
    assign mem_we    = accept && (opcode == hmt_pkg::OP_WRITE)
                    && (32'(point_index) < MAX_POINTS);

    assign oor_cur = (altitude < min_alt_reg) || (altitude > max_alt_reg);
    assign n_cur   = (32'(count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                   : CNT_W'(count_reg);

    // last read re-fetches point 0 to form the closing segment
    assign raddr = (cnt_reg == n_reg) ? '0 : cnt_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        alt_next       = alt_reg;
        azm_next       = azm_reg;
        oor_next       = oor_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_first_next  = 1'b0;
        res_valid_next = res_valid_reg && !result_ready;
        res_bit_next   = res_bit_reg;
        seg_clear      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == hmt_pkg::OP_QUERY))
                begin
                    alt_next  = altitude;
                    azm_next  = hmt_pkg::az_reduce(azimuth);
                    oor_next  = oor_cur;
                    n_next    = n_cur;
                    cnt_next  = '0;
                    seg_clear = 1'b1;
                    if (oor_cur || (n_cur == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                rd_vld_next   = 1'b1;
                rd_first_next = (cnt_reg == '0);
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !seg_sts.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next = 1'b1;
                    res_bit_next   = oor_reg | seg_sts.acc;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            rd_vld_reg    <= rd_vld_next;
            rd_first_reg  <= rd_first_next;
            res_valid_reg <= res_valid_next;
            oor_reg       <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alt_reg     <= alt_next;
        azm_reg     <= azm_next;
        res_bit_reg <= res_bit_next;
    end

    assign seg_ctl.clear = seg_clear;
    assign seg_ctl.valid = rd_vld_reg;
    assign seg_ctl.first = rd_first_reg;

    hmt_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(point_index)),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    hmt_seg_unit u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (seg_ctl),
        .target_az  (azm_reg),
        .target_alt (alt_reg),
        .point      (rdata),
        .sts        (seg_sts)
    );

endmodule

// ===== hw/rtl/hmt_point_mem.sv =====
// Outline point store: one write port, one registered read port.
// Depends on hmt_pkg (point_t).
module hmt_point_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  hmt_pkg::point_t      wdata,
    input  logic [AW-1:0]        raddr,
    output hmt_pkg::point_t      rdata
);

    hmt_pkg::point_t mem_reg [DEPTH];
    hmt_pkg::point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hmt_seg_unit.sv =====
// Shared segment unit: azimuth offset, straddle test, cross-multiplied
// altitude compare and crossing-parity accumulator. Depends on hmt_pkg.
module hmt_seg_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hmt_pkg::seg_ctl_t                  ctl,
    input  logic [hmt_pkg::AZ_W-1:0]           target_az,
    input  logic signed [hmt_pkg::ALT_W-1:0]   target_alt,
    input  hmt_pkg::point_t                    point,
    output hmt_pkg::seg_sts_t                  sts
);

    logic signed [17:0] t_raw;
    logic signed [17:0] t_wrap;
    logic signed [15:0] x_next;

    logic               v1_reg;
    logic               first1_reg;
    logic signed [15:0] x1_reg;
    logic signed [hmt_pkg::ALT_W-1:0] a1_reg;
    logic signed [15:0] xp_reg;
    logic signed [hmt_pkg::ALT_W-1:0] ap_reg;

    logic signed [16:0] d_next;
    logic               qual_next;
    logic               v2_reg;
    logic               qual_reg;
    logic               dpos_reg;
    logic signed [30:0] p1_reg;
    logic signed [30:0] p2_reg;
    logic signed [31:0] p3_reg;

    logic signed [32:0] num;
    logic signed [32:0] rhs;
    logic               hit;
    logic               acc_reg;

    // offset in [-18000, 18000)
    always_comb
    begin
        t_raw = $signed({2'b00, target_az}) - $signed({2'b00, point.az}) + 18'sd18000;
        if (t_raw < 18'sd0)
        begin
            t_wrap = t_raw + 18'sd36000;
        end
        else if (t_raw >= 18'sd36000)
        begin
            t_wrap = t_raw - 18'sd36000;
        end
        else
        begin
            t_wrap = t_raw;
        end
        x_next = 16'(t_wrap - 18'sd18000);
    end

    always_comb
    begin
        d_next    = 17'(x1_reg) - 17'(xp_reg);
        qual_next = !((xp_reg > 16'sd0) && (x1_reg > 16'sd0))
                 && !((xp_reg < 16'sd0) && (x1_reg < 16'sd0))
                 && (d_next != 17'sd0)
                 && (d_next > -17'sd18000) && (d_next < 17'sd18000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            v1_reg     <= ctl.valid;
            first1_reg <= ctl.first;
            v2_reg     <= v1_reg && !first1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= x_next;
        a1_reg <= point.alt;
        if (v1_reg)
        begin
            xp_reg   <= x1_reg;
            ap_reg   <= a1_reg;
            qual_reg <= qual_next;
            dpos_reg <= (d_next > 17'sd0);
            p1_reg   <= ap_reg * x1_reg;
            p2_reg   <= a1_reg * xp_reg;
            p3_reg   <= target_alt * d_next;
        end
    end

    always_comb
    begin
        num = 33'(p1_reg) - 33'(p2_reg);
        rhs = 33'(p3_reg);
        hit = qual_reg && (dpos_reg ? (num > rhs) : (num < rhs));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            acc_reg <= 1'b0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg ^ hit;
        end
    end

    assign sts.busy = v1_reg || v2_reg;
    assign sts.acc  = acc_reg;

endmodule

// ===== dv/tb_horizon_mask_test.sv =====
// Testbench for horizon_mask_test: point writes and target queries against an
// in-bench crossing-number predictor, with random stalls on both channels.
// Depends on hmt_pkg and the horizon_mask_test RTL.
module tb_horizon_mask_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AZ_W        = hmt_pkg::AZ_W;
    localparam int ALT_W       = hmt_pkg::ALT_W;
    localparam int CFG_W       = hmt_pkg::CFG_W;
    localparam int CFG_IDX_W   = hmt_pkg::CFG_IDX_W;
    localparam int CNT_CFG_W   = hmt_pkg::CNT_CFG_W;
    localparam int NPTS        = 64;
    localparam int DRAIN       = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_ready;
    logic                     opcode;
    logic [5:0]               point_index;
    logic [AZ_W-1:0]          azimuth;
    logic signed [ALT_W-1:0]  altitude;
    logic                     result_valid;
    logic                     result_ready;
    logic                     under_horizon;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;

    logic [AZ_W-1:0]          pt_az [NPTS];
    logic signed [ALT_W-1:0]  pt_alt [NPTS];
    logic signed [ALT_W-1:0]  lim_lo;
    logic signed [ALT_W-1:0]  lim_hi;
    logic [CNT_CFG_W-1:0]     pts_used;

    logic                     pending_masks [$];
    int                       mismatches;
    int                       cycles;
    bit                       steady;

    horizon_mask_test dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .point_index   (point_index),
        .azimuth       (azimuth),
        .altitude      (altitude),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .under_horizon (under_horizon),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic longint az_delta(input logic [AZ_W-1:0] az,
                                        input logic [AZ_W-1:0] paz);
        return ((longint'(az) - longint'(paz) + 90000) % 36000) - 18000;
    endfunction

    function automatic logic calc_masked(input logic [AZ_W-1:0] az,
                                         input logic signed [ALT_W-1:0] alt);
        logic   r;
        int     n;
        int     i;
        int     j;
        longint x1;
        longint x2;
        longint d;
        longint num;
        longint rhs;
        r = (alt < lim_lo) || (alt > lim_hi);
        n = (pts_used > NPTS) ? NPTS : int'(pts_used);
        if (!r)
        begin
            for (i = 0; i < n; i++)
            begin
                j  = (i + 1 == n) ? 0 : i + 1;
                x1 = az_delta(az, pt_az[i]);
                x2 = az_delta(az, pt_az[j]);
                d  = x2 - x1;
                if (x1 * x2 <= 0 && d != 0 && d < 18000 && d > -18000)
                begin
                    num = longint'(pt_alt[i]) * x2 - longint'(pt_alt[j]) * x1;
                    rhs = longint'(alt) * d;
                    if ((d > 0) ? (num > rhs) : (num < rhs))
                        r = ~r;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [AZ_W-1:0] rand_az();
        if ($urandom_range(0, 7) == 0)
            return AZ_W'($urandom());
        return AZ_W'($urandom_range(0, 35999));
    endfunction

    function automatic logic signed [ALT_W-1:0] rand_alt();
        if ($urandom_range(0, 7) == 0)
            return ALT_W'($urandom());
        return ALT_W'(int'($urandom_range(0, 18000)) - 9000);
    endfunction

    task automatic send_item(input logic op, input logic [5:0] idx,
                             input logic [AZ_W-1:0] az,
                             input logic signed [ALT_W-1:0] alt);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        opcode      <= op;
        point_index <= idx;
        azimuth     <= az;
        altitude    <= alt;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (op == hmt_pkg::OP_WRITE)
        begin
            pt_az[idx]  = az;
            pt_alt[idx] = alt;
        end
        else
            pending_masks.push_back(calc_masked(az, alt));
    endtask

    // drop valid, wait for every queued answer, then let the block drain
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            hmt_pkg::CFG_MIN_ALT: lim_lo = val;
            hmt_pkg::CFG_MAX_ALT: lim_hi = val;
            hmt_pkg::CFG_POINTS:  pts_used = val[CNT_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_empty_outline();
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd0, 15'sd0);
        send_item(hmt_pkg::OP_QUERY, 6'd63, 16'd35999, 15'sd9000);
    endtask

    task automatic test_altitude_limits();
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd100, 15'sd9001);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd100, -15'sd9001);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd100, -15'sd16384);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd100, 15'sd16383);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd100, -15'sd9000);
    endtask

    task automatic test_square_outline();
        send_item(hmt_pkg::OP_WRITE, 6'd0, 16'd0, 15'sd3000);
        send_item(hmt_pkg::OP_WRITE, 6'd1, 16'd9000, 15'sd3000);
        send_item(hmt_pkg::OP_WRITE, 6'd2, 16'd18000, 15'sd3000);
        send_item(hmt_pkg::OP_WRITE, 6'd3, 16'd27000, 15'sd3000);
        send_item(hmt_pkg::OP_WRITE, 6'd63, 16'hFFFF, -15'sd16384);
        settle();
        write_reg(hmt_pkg::CFG_POINTS, CFG_W'(4));
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd4500, 15'sd1000);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd4500, 15'sd3000);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd4500, 15'sd5000);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd9000, 15'sd1000);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'hFFFF, 15'sd0);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd13500, -15'sd9000);
    endtask

    task automatic test_single_point();
        settle();
        write_reg(hmt_pkg::CFG_POINTS, CFG_W'(1));
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd0, -15'sd100);
    endtask

    task automatic test_equal_azimuths();
        send_item(hmt_pkg::OP_WRITE, 6'd1, 16'd36000, 15'sd5000);
        settle();
        write_reg(hmt_pkg::CFG_POINTS, CFG_W'(2));
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd18000, 15'sd0);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd0, 15'sd0);
    endtask

    task automatic test_inverted_limits();
        settle();
        write_reg(hmt_pkg::CFG_MIN_ALT, CFG_W'(3000));
        write_reg(hmt_pkg::CFG_MAX_ALT, CFG_W'(-3000));
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd4500, 15'sd0);
        send_item(hmt_pkg::OP_QUERY, 6'd0, 16'd4500, 15'sd3000);
    endtask

    task automatic test_random_masks();
        int lo_tab [8] = '{-9000, -9000, -16384, -9000, -2000, 0, 5000, -9000};
        int hi_tab [8] = '{9000, 9000, 16383, 9000, 4500, 0, -5000, 9000};
        int cnt_tab [8] = '{64, 7, 127, 64, 16, 3, 32, 2};
        int                      p;
        int                      k;
        int                      n;
        int                      base;
        logic [5:0]              idx;
        logic [AZ_W-1:0]         az;
        logic signed [ALT_W-1:0] alt;
        for (k = 0; k < NPTS; k++)
            send_item(hmt_pkg::OP_WRITE, 6'(k), rand_az(), rand_alt());
        for (p = 0; p < 8; p++)
        begin
            settle();
            write_reg(hmt_pkg::CFG_MIN_ALT, CFG_W'(lo_tab[p]));
            write_reg(hmt_pkg::CFG_MAX_ALT, CFG_W'(hi_tab[p]));
            write_reg(hmt_pkg::CFG_POINTS, CFG_W'(cnt_tab[p]));
            steady = (p == 3);
            n = (cnt_tab[p] > NPTS) ? NPTS : cnt_tab[p];
            for (k = 0; k < 55; k++)
            begin
                base = $urandom_range(0, n - 1);
                if ($urandom_range(0, 9) < 3)
                begin
                    idx = 6'($urandom());
                    az  = rand_az();
                    // repeat the previous point's azimuth, sometimes a full turn up
                    if ($urandom_range(0, 5) == 0)
                        az = pt_az[6'(idx - 6'd1)]
                           + ($urandom_range(0, 1) ? hmt_pkg::AZ_FULL : 16'd0);
                    send_item(hmt_pkg::OP_WRITE, idx, az, rand_alt());
                end
                else
                begin
                    if ($urandom_range(0, 1))
                        az = pt_az[base] + AZ_W'($urandom_range(0, 400)) - 16'd200;
                    else
                        az = rand_az();
                    if ($urandom_range(0, 1))
                        alt = pt_alt[base] + ALT_W'($urandom_range(0, 200)) - 15'sd100;
                    else
                        alt = rand_alt();
                    send_item(hmt_pkg::OP_QUERY, 6'($urandom()), az, alt);
                end
            end
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
        result_ready <= steady || ($urandom_range(0, 99) >= 19);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none actual %0b",
                         $time, under_horizon);
                mismatches++;
            end
            else if (pending_masks[0] !== under_horizon)
            begin
                $display("%0t: under_horizon mismatch, expected %0b actual %0b",
                         $time, pending_masks[0], under_horizon);
                mismatches++;
                void'(pending_masks.pop_front());
            end
            else
                void'(pending_masks.pop_front());
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        opcode       = hmt_pkg::OP_WRITE;
        point_index  = '0;
        azimuth      = '0;
        altitude     = '0;
        cfg_we       = 1'b0;
        cfg_index    = hmt_pkg::CFG_MIN_ALT;
        cfg_data     = '0;
        steady       = 1'b0;
        mismatches   = 0;
        lim_lo       = hmt_pkg::MIN_ALT_RST;
        lim_hi       = hmt_pkg::MAX_ALT_RST;
        pts_used     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_outline();
        test_altitude_limits();
        test_square_outline();
        test_single_point();
        test_equal_azimuths();
        test_inverted_limits();
        test_random_masks();
        settle();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
